[rtl/sxf_pkg.sv]
// ---------------------------------------------------------------------------
// sxf_pkg: shared types, codes and byte selection for the template filler
// Holds the token kind codes, the history port command struct and the
// function that forms one message byte from a template token.
// ---------------------------------------------------------------------------
`default_nettype none

package sxf_pkg;

  // Token kinds
  localparam logic [3:0] KIND_KEEP     = 4'd0;
  localparam logic [3:0] KIND_VAL_LO   = 4'd1;
  localparam logic [3:0] KIND_CHAN     = 4'd2;
  localparam logic [3:0] KIND_LSB7     = 4'd3;
  localparam logic [3:0] KIND_MSB7     = 4'd4;
  localparam logic [3:0] KIND_CHAN_TAG = 4'd5;
  localparam logic [3:0] KIND_GLOBAL   = 4'd6;
  localparam logic [3:0] KIND_LSN      = 4'd7;
  localparam logic [3:0] KIND_MSN      = 4'd8;
  localparam logic [3:0] KIND_SPLIT1   = 4'd9;
  localparam logic [3:0] KIND_SPLIT2   = 4'd10;
  localparam logic [3:0] KIND_SPLIT3   = 4'd11;
  localparam logic [3:0] KIND_SPLIT4   = 4'd12;
  localparam logic [3:0] KIND_SUM_NEG  = 4'd13;
  localparam logic [3:0] KIND_SUM_MASK = 4'd14;

  // Configuration register indexes
  localparam logic CFG_PARAM_VALUE  = 1'b0;
  localparam logic CFG_MIDI_CHANNEL = 1'b1;

  // Commands to the history ring buffer
  typedef struct packed {
    logic       wr_en;
    logic [7:0] wr_byte;
    logic       rd_start;
    logic       rd_step;
  } hist_cmd_t;

  // Registered read of the global table
  typedef struct packed {
    logic       set;
    logic [7:0] data;
  } glob_rd_t;

  // Channel numbered from one, minus one, clamped to 0..15
  function automatic logic [3:0] chan_clamp(input logic [4:0] chan);
    logic [3:0] res;
    if (chan == 5'd0) begin
      res = 4'd0;
    end else if (chan > 5'd16) begin
      res = 4'hf;
    end else begin
      res = 4'(chan - 5'd1);
    end
    return res;
  endfunction

  // Form the message byte for one template token
  function automatic logic [7:0] sel_byte(
    input logic [3:0]  kind,
    input logic [7:0]  tbyte,
    input logic [3:0]  data,
    input logic [15:0] v,
    input logic [4:0]  chan,
    input logic [6:0]  sum7,
    input glob_rd_t    glob
  );
    logic [7:0] b;
    b = tbyte;
    unique case (kind)
      KIND_VAL_LO:   b = v[7:0];
      KIND_CHAN:     b = {4'd0, chan_clamp(chan)};
      KIND_LSB7:     b = {1'b0, v[6:0]};
      KIND_MSB7:     b = v[14:7];
      KIND_CHAN_TAG: b = {1'b0, data[2:0], chan_clamp(chan)};
      KIND_GLOBAL:   b = glob.set ? glob.data : tbyte;
      KIND_LSN:      b = {4'd0, v[3:0]};
      KIND_MSN:      b = {4'd0, v[7:4]};
      KIND_SPLIT1:   b = {4'd0, v[15:12]};
      KIND_SPLIT2:   b = {4'd0, v[11:8]};
      KIND_SPLIT3:   b = {4'd0, v[7:4]};
      KIND_SPLIT4:   b = {4'd0, v[3:0]};
      KIND_SUM_NEG:  b = (sum7 == 7'd0) ? 8'd0 : 8'(9'd128 - {2'b0, sum7});
      KIND_SUM_MASK: b = {1'b0, sum7};
      default:       b = tbyte;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

[rtl/sxf_hist.sv]
// ---------------------------------------------------------------------------
// sxf_hist: ring buffer of emitted message bytes
// Writes each emitted byte at the write pointer and reads back newest
// first, one byte a cycle, through a registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module sxf_hist #(
  parameter int HISTORY_DEPTH = 16
) (
  input  wire                clk,
  input  wire                rst,
  input  sxf_pkg::hist_cmd_t cmd,
  output logic [7:0]         rd_data
);

  localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(HISTORY_DEPTH - 1);

  logic [7:0]    mem [HISTORY_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;

  // Advance the write pointer with wrap
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
    end else if (cmd.wr_en) begin
      wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
    end
  end

  // Store the emitted byte
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_ptr] <= cmd.wr_byte;
    end
  end

  // Start at the newest byte, step backward, register the read
  always_ff @(posedge clk) begin
    if (cmd.rd_start) begin
      rd_ptr <= (wr_ptr == '0) ? LAST : wr_ptr - 1'b1;
    end else if (cmd.rd_step) begin
      rd_ptr  <= (rd_ptr == '0) ? LAST : rd_ptr - 1'b1;
      rd_data <= mem[rd_ptr];
    end
  end

endmodule

`default_nettype wire

[rtl/sxf_glob.sv]
// ---------------------------------------------------------------------------
// sxf_glob: table of global variables
// Keeps the low byte of each global and a set flag; the flags clear on
// reset so every global reads as unset until written with a value >= 0.
// ---------------------------------------------------------------------------
`default_nettype none

module sxf_glob #(
  parameter int GLOBAL_COUNT = 16
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                wr_en,
  input  wire  [3:0]         wr_index,
  input  wire  [15:0]        wr_value,
  input  wire                rd_en,
  input  wire  [3:0]         rd_index,
  output sxf_pkg::glob_rd_t  rd
);

  localparam int GW = (GLOBAL_COUNT > 1) ? $clog2(GLOBAL_COUNT) : 1;

  logic [7:0]              mem [GLOBAL_COUNT];
  logic [GLOBAL_COUNT-1:0] set_bits;
  logic [8:0]              wr_ext;
  logic [8:0]              rd_ext;
  logic [GW-1:0]           wr_addr;
  logic [GW-1:0]           rd_addr;
  logic                    wr_ok;
  logic                    rd_ok;

  assign wr_ext  = {5'd0, wr_index};
  assign rd_ext  = {5'd0, rd_index};
  assign wr_addr = wr_ext[GW-1:0];
  assign rd_addr = rd_ext[GW-1:0];
  assign wr_ok   = wr_en && (wr_ext < 9'(GLOBAL_COUNT));
  assign rd_ok   = rd_ext < 9'(GLOBAL_COUNT);

  // Track which globals hold a non-negative value
  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits <= '0;
    end else if (wr_ok) begin
      set_bits[wr_addr] <= !wr_value[15];
    end
  end

  // Store the low byte
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_addr] <= wr_value[7:0];
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd.set  <= rd_ok && set_bits[rd_addr];
      rd.data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/sysex_template_byte_filler.sv]
// ---------------------------------------------------------------------------
// sysex_template_byte_filler: fills a system-exclusive template bytewise
// Substitutes value, channel and global fields into template bytes and
// computes checksums over the preceding bytes of the same message.
// ---------------------------------------------------------------------------
//
// Channel   Dir  Beat contents
// s_*       in   one template token or one global write
// m_*       out  one message byte per template token
// cfg_*     in   parameter value and MIDI channel registers
//
// A global write only updates the global table. A template token passes the idle,
// sum and emit states; for a checksum over n bytes, 0 <= n <= 15, the single
// accumulator adds the low seven bits of one history byte per cycle in the sum state.
// Reset clears the sequencer, the message byte count, the history pointer
// and all global flags. A stalled output holds the sequencer before the
// history write; s_tready stays low until the byte is in the output register.
`default_nettype none

module sysex_template_byte_filler #(
  parameter int HISTORY_DEPTH = 16,
  parameter int GLOBAL_COUNT  = 16
) (
  input  wire         clk,
  input  wire         rst,
  // Input stream
  input  wire         s_tvalid,
  output logic        s_tready,
  // [7:0] template_byte, [11:8] token_kind, [15:12] token_data,
  // [16] first_of_message, [20:17] global_index, [36:21] global_value
  input  wire  [39:0] s_tdata,
  // [0] action
  input  wire  [0:0]  s_tuser,
  // Output stream
  output logic        m_tvalid,
  input  wire         m_tready,
  // [7:0] out_byte, [8] out_first
  output logic [15:0] m_tdata,
  // Configuration
  input  wire         cfg_we,
  input  wire  [0:0]  cfg_index,
  input  wire  [15:0] cfg_data
);

  localparam int SW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [SW-1:0] SEEN_MAX = SW'(HISTORY_DEPTH - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SUM  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]         state;
  logic [15:0]        param_value;
  logic [4:0]         midi_channel;
  logic [SW-1:0]      bytes_seen;
  logic [3:0]         remaining;
  logic               rd_vld;
  logic [6:0]         acc;
  logic [3:0]         kind;
  logic [7:0]         tbyte;
  logic [3:0]         tdata_q;
  logic               first;
  logic [7:0]         out_byte;
  logic               out_first;

  logic               in_acc;
  logic               proc_acc;
  logic               emit_go;
  logic [SW-1:0]      seen_eff;
  logic [7:0]         seen_ext;
  logic [7:0]         data_ext;
  logic [3:0]         n_terms;
  logic               is_sum;
  logic [7:0]         new_byte;
  logic [7:0]         hist_rd;
  sxf_pkg::hist_cmd_t hcmd;
  sxf_pkg::glob_rd_t  grd;

  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign proc_acc = in_acc && !s_tuser[0];
  assign emit_go  = (state == ST_EMIT) && (!m_tvalid || m_tready);
  assign m_tdata  = {7'd0, out_first, out_byte};

  // Clamp the look-back to the bytes already in this message
  assign seen_eff = s_tdata[16] ? '0 : bytes_seen;
  assign seen_ext = 8'(seen_eff);
  assign data_ext = {4'd0, s_tdata[15:12]};
  assign n_terms  = (data_ext < seen_ext) ? s_tdata[15:12] : 4'(seen_ext);
  assign is_sum   = (s_tdata[11:8] == sxf_pkg::KIND_SUM_NEG) ||
                    (s_tdata[11:8] == sxf_pkg::KIND_SUM_MASK);

  assign new_byte = sxf_pkg::sel_byte(kind, tbyte, tdata_q, param_value, midi_channel,
                                      acc, grd);

  // History port commands
  assign hcmd.wr_en    = emit_go;
  assign hcmd.wr_byte  = new_byte;
  assign hcmd.rd_start = proc_acc;
  assign hcmd.rd_step  = (state == ST_SUM) && (remaining != 4'd0);

  sxf_hist #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_hist (
    .clk     (clk),
    .rst     (rst),
    .cmd     (hcmd),
    .rd_data (hist_rd)
  );

  sxf_glob #(
    .GLOBAL_COUNT(GLOBAL_COUNT)
  ) u_glob (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (in_acc && s_tuser[0]),
    .wr_index (s_tdata[20:17]),
    .wr_value (s_tdata[36:21]),
    .rd_en    (proc_acc),
    .rd_index (s_tdata[15:12]),
    .rd       (grd)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      param_value  <= '0;
      midi_channel <= 5'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sxf_pkg::CFG_PARAM_VALUE:  param_value  <= cfg_data;
        sxf_pkg::CFG_MIDI_CHANNEL: midi_channel <= cfg_data[4:0];
        default:                   param_value  <= param_value;
      endcase
    end
  end

  // Sequencer: latch token, sum history bytes, emit
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      bytes_seen <= '0;
      remaining  <= '0;
      rd_vld     <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (proc_acc) begin
            bytes_seen <= seen_eff;
            remaining  <= is_sum ? n_terms : 4'd0;
            state      <= ST_SUM;
          end
        end
        ST_SUM: begin
          rd_vld <= hcmd.rd_step;
          if (hcmd.rd_step) begin
            remaining <= remaining - 4'd1;
          end else if (!rd_vld) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            if (bytes_seen != SEEN_MAX) begin
              bytes_seen <= bytes_seen + 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Hold the token fields and accumulate the checksum
  always_ff @(posedge clk) begin
    if (proc_acc) begin
      kind    <= s_tdata[11:8];
      tbyte   <= s_tdata[7:0];
      tdata_q <= s_tdata[15:12];
      first   <= s_tdata[16];
      acc     <= '0;
    end else if (rd_vld) begin
      acc <= acc + hist_rd[6:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_byte  <= new_byte;
      out_first <= first;
    end
  end

  // Message byte count stays below the history depth
  a_seen_max: assert property (@(posedge clk) disable iff (rst)
    bytes_seen <= SEEN_MAX)
    else $error("bytes_seen beyond history depth");

  // History reads come back only while summing
  a_rd_in_sum: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> (state == ST_SUM))
    else $error("history read outside sum phase");

  // A global write yields no output byte
  a_write_no_out: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser[0]) |=> !$rose(m_tvalid))
    else $error("output after global write");

  // Emitting always loads the output register
  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    emit_go |=> (m_tvalid && (state == ST_IDLE)))
    else $error("emit did not load output");

endmodule

`default_nettype wire
